### sv/eol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eol_pkg
// Shared widths, constants and word types for the extent offset locator.
// ----------------------------------------------------------------------------
package eol_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned OFFSET_W    = 9;
    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int unsigned SPAN_W      = WORD_W + BLOCK_SHIFT;

    typedef struct packed {
        logic [WORD_W-1:0] query_offset;
        logic [WORD_W-1:0] extent_start;
        logic [WORD_W-1:0] extent_length;
        logic              first_item;
        logic              last_item;
    } eol_item_t;

    typedef struct packed {
        logic                located;
        logic [WORD_W-1:0]   block_number;
        logic [OFFSET_W-1:0] offset_in_block;
        logic [WORD_W-1:0]   total_blocks;
        logic                total_saturated;
    } eol_result_t;

endpackage

### sv/eol_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eol_in_stage
// Input register: holds one extent word until the walk stage takes it.
// ----------------------------------------------------------------------------
module eol_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  eol_pkg::eol_item_t in_item,
    output logic               item_valid,
    input  logic               item_take,
    output eol_pkg::eol_item_t item
);
    import eol_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    eol_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

### sv/eol_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eol_walk
// Walk state, per-extent compare/subtract/accumulate and the result register.
// ----------------------------------------------------------------------------
module eol_walk (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_take,
    input  eol_pkg::eol_item_t   item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output eol_pkg::eol_result_t res
);
    import eol_pkg::*;

    logic [WORD_W-1:0]   remaining_reg, remaining_next;
    logic                hit_seen_reg, hit_seen_next;
    logic [WORD_W-1:0]   hit_block_reg, hit_block_next;
    logic [OFFSET_W-1:0] hit_offset_reg, hit_offset_next;
    logic [WORD_W-1:0]   block_sum_reg, block_sum_next;
    logic                clamped_reg, clamped_next;
    logic                res_valid_reg, res_valid_next;
    eol_result_t         res_reg, res_next;

    logic [WORD_W-1:0]   cur_remaining;
    logic                cur_hit;
    logic [WORD_W-1:0]   cur_block;
    logic [OFFSET_W-1:0] cur_offset;
    logic [WORD_W-1:0]   cur_sum;
    logic                cur_clamped;
    logic [SPAN_W-1:0]   span;
    logic                in_span;
    logic [WORD_W:0]     sum_wide;
    logic                fire;

    assign item_take = !item.last_item || !res_valid_reg || res_ready;
    assign fire      = item_valid && item_take;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        // first word restarts the walk from the query offset
        cur_remaining = item.first_item ? item.query_offset : remaining_reg;
        cur_hit       = item.first_item ? 1'b0 : hit_seen_reg;
        cur_block     = item.first_item ? '0 : hit_block_reg;
        cur_offset    = item.first_item ? '0 : hit_offset_reg;
        cur_sum       = item.first_item ? '0 : block_sum_reg;
        cur_clamped   = item.first_item ? 1'b0 : clamped_reg;

        span    = {item.extent_length, {BLOCK_SHIFT{1'b0}}};
        in_span = {{(SPAN_W-WORD_W){1'b0}}, cur_remaining} < span;

        remaining_next  = cur_remaining;
        hit_seen_next   = cur_hit;
        hit_block_next  = cur_block;
        hit_offset_next = cur_offset;
        if (!cur_hit) begin
            if (in_span) begin
                hit_seen_next   = 1'b1;
                hit_block_next  = item.extent_start + (cur_remaining >> BLOCK_SHIFT);
                hit_offset_next = OFFSET_W'(cur_remaining[BLOCK_SHIFT-1:0]);
            end else begin
                // span <= remaining here, so the difference fits the word
                remaining_next = cur_remaining - span[WORD_W-1:0];
            end
        end

        sum_wide = {1'b0, cur_sum} + {1'b0, item.extent_length};
        if (sum_wide[WORD_W]) begin
            block_sum_next = '1;
            clamped_next   = 1'b1;
        end else begin
            block_sum_next = sum_wide[WORD_W-1:0];
            clamped_next   = cur_clamped;
        end

        res_next.located         = hit_seen_next;
        res_next.block_number    = hit_seen_next ? hit_block_next : '0;
        res_next.offset_in_block = hit_seen_next ? hit_offset_next : '0;
        res_next.total_blocks    = block_sum_next;
        res_next.total_saturated = clamped_next;

        res_valid_next = res_valid_reg;
        if (res_ready) begin
            res_valid_next = 1'b0;
        end
        if (fire && item.last_item) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg  <= '0;
            hit_seen_reg   <= 1'b0;
            hit_block_reg  <= '0;
            hit_offset_reg <= '0;
            block_sum_reg  <= '0;
            clamped_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (fire) begin
                if (item.last_item) begin
                    remaining_reg  <= '0;
                    hit_seen_reg   <= 1'b0;
                    hit_block_reg  <= '0;
                    hit_offset_reg <= '0;
                    block_sum_reg  <= '0;
                    clamped_reg    <= 1'b0;
                end else begin
                    remaining_reg  <= remaining_next;
                    hit_seen_reg   <= hit_seen_next;
                    hit_block_reg  <= hit_block_next;
                    hit_offset_reg <= hit_offset_next;
                    block_sum_reg  <= block_sum_next;
                    clamped_reg    <= clamped_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && item.last_item) begin
            res_reg <= res_next;
        end
    end

endmodule

### sv/extent_offset_locator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_offset_locator_core
// Maps a file byte offset to a tape block by walking a streamed extent list.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per extent. The word with s_first_item set restarts
//   the walk and carries the query offset; the word with s_last_item set
//   closes the list and yields one result word on the m_ channel. An empty
//   list is a single word with zero length and both flags set.
//   m_ channel: located flag, block number and in-block offset of the first
//   extent holding the offset, plus the saturating block total.
// Throughput: one extent word per cycle while no unread result blocks a last
//   word, set by the compare/subtract/accumulate loop on the walk state.
// Path: a last word is accepted into the input register, which feeds the
//   walk; the walk loads the result register when it takes that word.
// Reset: aresetn (synchronous, active low) clears the walk state and empties
//   both registers. If the receiver stalls, the result word holds; non-last
//   words keep flowing, and a further last word waits in the input register.
// ----------------------------------------------------------------------------
module extent_offset_locator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [eol_pkg::WORD_W-1:0]        s_byte_offset,
    input  logic [eol_pkg::WORD_W-1:0]        s_extent_start,
    input  logic [eol_pkg::WORD_W-1:0]        s_extent_length,
    input  logic                              s_first_item,
    input  logic                              s_last_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_located,
    output logic [eol_pkg::WORD_W-1:0]        m_block_number,
    output logic [eol_pkg::OFFSET_W-1:0]      m_offset_in_block,
    output logic [eol_pkg::WORD_W-1:0]        m_total_blocks,
    output logic                              m_total_saturated
);
    import eol_pkg::*;

    eol_item_t   in_item;
    eol_item_t   item;
    logic        item_valid;
    logic        item_take;
    eol_result_t res;

    assign in_item.query_offset  = s_byte_offset;
    assign in_item.extent_start  = s_extent_start;
    assign in_item.extent_length = s_extent_length;
    assign in_item.first_item    = s_first_item;
    assign in_item.last_item     = s_last_item;

    eol_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    eol_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_valid  (m_valid),
        .res_ready  (m_ready),
        .res        (res)
    );

    assign m_located         = res.located;
    assign m_block_number    = res.block_number;
    assign m_offset_in_block = res.offset_in_block;
    assign m_total_blocks    = res.total_blocks;
    assign m_total_saturated = res.total_saturated;

endmodule

### tb/extent_offset_locator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_offset_locator_core_tb
// Self-checking bench for the extent walk. A short stimulus table covers
// the edge cases: empty list, first and last byte of an extent, block number
// wrap, saturating total, stray words with no first flag and a restart in
// mid-walk. A random phase of extent lists follows, most of them well formed
// and some broken. Each result word is checked against its fixed table row
// or a model of the walk. Both sides idle at random, with one long output
// stall and one point where input pauses until every result has come.
// ----------------------------------------------------------------------------
module extent_offset_locator_core_tb;
    import eol_pkg::*;

    localparam int unsigned RANDOM_WORDS = 850;
    localparam int unsigned STALL_CYCLES = 300;
    localparam int unsigned WDOG_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        eol_item_t   word;
        logic        fixed;
        eol_result_t want;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [WORD_W-1:0]   s_byte_offset;
    logic [WORD_W-1:0]   s_extent_start;
    logic [WORD_W-1:0]   s_extent_length;
    logic                s_first_item;
    logic                s_last_item;
    logic                m_valid;
    logic                m_ready;
    logic                m_located;
    logic [WORD_W-1:0]   m_block_number;
    logic [OFFSET_W-1:0] m_offset_in_block;
    logic [WORD_W-1:0]   m_total_blocks;
    logic                m_total_saturated;

    // walk model state
    logic [WORD_W:0]     walk_left;
    logic                hit_found;
    logic [WORD_W-1:0]   hit_blk;
    logic [OFFSET_W-1:0] hit_ofs;
    logic [WORD_W-1:0]   blk_total;
    logic                total_clamped;

    eol_result_t expected_results[$];
    stim_row_t   stim_table[$];

    int  words_sent;
    int  results_checked;
    int  located_seen;
    int  clamped_seen;
    int  errors;
    bit  calm;

    extent_offset_locator_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_offset     (s_byte_offset),
        .s_extent_start    (s_extent_start),
        .s_extent_length   (s_extent_length),
        .s_first_item      (s_first_item),
        .s_last_item       (s_last_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_located         (m_located),
        .m_block_number    (m_block_number),
        .m_offset_in_block (m_offset_in_block),
        .m_total_blocks    (m_total_blocks),
        .m_total_saturated (m_total_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic note_failure(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic clear_walk();
        walk_left     = '0;
        hit_found     = 1'b0;
        hit_blk       = '0;
        hit_ofs       = '0;
        blk_total     = '0;
        total_clamped = 1'b0;
    endtask

    // One extent step of the walk; emit is set on a last word.
    task automatic advance_walk(input eol_item_t w, output logic emit,
                                output eol_result_t r);
        logic [63:0]     span;
        logic [63:0]     idx;
        logic [WORD_W:0] sum;
        if (w.first_item) begin
            clear_walk();
            walk_left = {1'b0, w.query_offset};
        end
        span = {32'd0, w.extent_length} << BLOCK_SHIFT;
        if (!hit_found) begin
            if ({31'd0, walk_left} < span) begin
                idx       = {31'd0, walk_left} >> BLOCK_SHIFT;
                hit_found = 1'b1;
                hit_blk   = w.extent_start + idx[WORD_W-1:0];
                hit_ofs   = walk_left[OFFSET_W-1:0];
            end else begin
                walk_left = walk_left - span[WORD_W:0];
            end
        end
        sum = {1'b0, blk_total} + {1'b0, w.extent_length};
        if (sum[WORD_W]) begin
            blk_total     = '1;
            total_clamped = 1'b1;
        end else begin
            blk_total = sum[WORD_W-1:0];
        end
        emit = w.last_item;
        r    = '0;
        if (emit) begin
            r.located         = hit_found;
            r.block_number    = hit_found ? hit_blk : '0;
            r.offset_in_block = hit_found ? hit_ofs : '0;
            r.total_blocks    = blk_total;
            r.total_saturated = total_clamped;
            clear_walk();
        end
    endtask

    // Entered at a clock edge; returns at the edge the word was taken.
    task automatic send_word(input eol_item_t w, input logic fixed,
                             input eol_result_t want);
        logic        emit;
        eol_result_t pred;
        while (!calm && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_byte_offset   <= w.query_offset;
        s_extent_start  <= w.extent_start;
        s_extent_length <= w.extent_length;
        s_first_item    <= w.first_item;
        s_last_item     <= w.last_item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        advance_walk(w, emit, pred);
        if (emit) begin
            expected_results.push_back(fixed ? want : pred);
        end
    endtask

    task automatic add_row(input logic [31:0] ofs, input logic [31:0] start,
                           input logic [31:0] len, input logic first,
                           input logic last, input logic fixed,
                           input logic loc, input logic [31:0] blk,
                           input logic [8:0] in_blk, input logic [31:0] tot,
                           input logic sat);
        stim_row_t row;
        row.word = '{query_offset: ofs, extent_start: start, extent_length: len,
                     first_item: first, last_item: last};
        row.fixed = fixed;
        row.want  = '{located: loc, block_number: blk, offset_in_block: in_blk,
                      total_blocks: tot, total_saturated: sat};
        stim_table.push_back(row);
    endtask

    task automatic run_random_list();
        logic [31:0] len_q [0:19];
        logic [63:0] span_total;
        logic [63:0] cum;
        logic [31:0] offset;
        eol_item_t   w;
        int          n;
        int          k;
        int          pick;
        int          flavour;
        n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        span_total = '0;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0:       len_q[k] = '0;
                1:       len_q[k] = $urandom();
                2:       len_q[k] = $urandom_range(0, 4096);
                default: len_q[k] = $urandom_range(1, 8);
            endcase
            span_total += {32'd0, len_q[k]} << BLOCK_SHIFT;
        end
        case ($urandom_range(3))
            0: offset = $urandom();
            1: begin
                // land on an extent boundary or one byte short of it
                pick = $urandom_range(0, n - 1);
                cum  = '0;
                for (k = 0; k < pick; k++) cum += {32'd0, len_q[k]} << BLOCK_SHIFT;
                offset = cum[31:0] - $urandom_range(0, 1);
            end
            default: begin
                cum    = {$urandom(), $urandom()} % (span_total + 64'd600);
                offset = cum[31:0];
            end
        endcase
        flavour = $urandom_range(19);
        if (flavour == 3) begin
            // stray word between lists
            w = '{query_offset: $urandom(), extent_start: $urandom(),
                  extent_length: $urandom_range(0, 3), first_item: 1'b0,
                  last_item: 1'b0};
            send_word(w, 1'b0, '0);
        end
        for (k = 0; k < n; k++) begin
            w.query_offset  = (k == 0) ? offset : $urandom();
            w.extent_start  = ($urandom_range(3) == 0) ?
                              32'hFFFF_FFFF - $urandom_range(0, 15) : $urandom();
            w.extent_length = len_q[k];
            w.first_item    = (k == 0 && flavour != 0) ||
                              (k != 0 && k == n / 2 && flavour == 2);
            w.last_item     = (k == n - 1) && flavour != 1;
            send_word(w, 1'b0, '0);
        end
    endtask

    // stimulus
    initial begin : stimulus
        int list_no;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_byte_offset   = '0;
        s_extent_start  = '0;
        s_extent_length = '0;
        s_first_item    = 1'b0;
        s_last_item     = 1'b0;
        calm            = 1'b0;
        words_sent      = 0;
        errors          = 0;
        clear_walk();

        //      offset        start         length        f  l  fx loc block       ofs  total       sat
        add_row(32'd0,        32'd5,        32'd0,        1, 1, 1, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd0,        32'd100,      32'd1,        1, 1, 1, 1, 32'd100,     0,   32'd1,       0);
        add_row(32'd511,      32'd100,      32'd1,        1, 1, 1, 1, 32'd100,     511, 32'd1,       0);
        add_row(32'd512,      32'd100,      32'd1,        1, 1, 1, 0, 32'd0,       0,   32'd1,       0);
        add_row(32'hFFFFFFFF, 32'd0,        32'hFFFFFFFF, 1, 1, 1, 1, 32'h007FFFFF, 511, 32'hFFFFFFFF, 0);
        add_row(32'd1024,     32'hFFFFFFFF, 32'd4,        1, 1, 1, 1, 32'd1,       0,   32'd4,       0);
        add_row(32'd0,        32'd0,        32'hFFFFFFFF, 1, 0, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'hFFFFFFFF, 32'd7,        32'd2,        0, 1, 1, 1, 32'd0,       0,   32'hFFFFFFFF, 1);
        add_row(32'd1000,     32'd10,       32'd1,        1, 0, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd0,        32'd50,       32'd3,        0, 1, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd0,        32'd20,       32'd1,        1, 0, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd0,        32'd40,       32'd5,        0, 1, 0, 0, 32'd0,       0,   32'd0,       0);
        // no first flag after a result: walk starts from zero
        add_row(32'hFFFFFFFF, 32'd30,       32'd2,        0, 1, 1, 1, 32'd30,      0,   32'd2,       0);
        add_row(32'd0,        32'd9,        32'd0,        1, 0, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd0,        32'd77,       32'd1,        0, 1, 0, 0, 32'd0,       0,   32'd0,       0);
        // restart in mid-walk
        add_row(32'd0,        32'd0,        32'd0,        1, 0, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd600,      32'd3,        32'd2,        1, 1, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd0,        32'd0,        32'd0,        0, 0, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd5000,     32'd1,        32'd2,        1, 0, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd0,        32'd2,        32'd3,        0, 1, 1, 0, 32'd0,       0,   32'd5,       0);
        add_row(32'd0,        32'd0,        32'hFFFFFFFE, 1, 0, 0, 0, 32'd0,       0,   32'd0,       0);
        add_row(32'd0,        32'd0,        32'd1,        0, 1, 0, 0, 32'd0,       0,   32'd0,       0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            send_word(stim_table[i].word, stim_table[i].fixed, stim_table[i].want);
        end

        list_no = 0;
        while (words_sent < stim_table.size() + RANDOM_WORDS) begin
            list_no++;
            calm = (words_sent >= 420 && words_sent < 560);
            if (list_no == 30 && expected_results.size() != 0) begin
                // hold input until the output side has caught up
                s_valid <= 1'b0;
                while (expected_results.size() != 0) @(posedge aclk);
            end
            run_random_list();
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("Covered %0d extent words in %0d lists, %0d result words checked",
                 words_sent, list_no, results_checked);
        $display("Results located: %0d, totals clamped: %0d, mismatches: %0d",
                 located_seen, clamped_seen, errors);
        if (errors == 0) begin
            $display("extent_offset_locator_core_tb OK");
        end else begin
            $display("extent_offset_locator_core_tb NOT OK");
        end
        $finish;
    end

    // result side: random back-pressure plus one long stall
    initial begin : result_sink
        eol_result_t want;
        int          hold_left;
        bit          held_once;
        hold_left       = 0;
        held_once       = 1'b0;
        results_checked = 0;
        located_seen    = 0;
        clamped_seen    = 0;
        m_ready         = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    note_failure("result word with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (m_located !== want.located)
                        note_failure($sformatf("located got %0b want %0b",
                                               m_located, want.located));
                    if (m_block_number !== want.block_number)
                        note_failure($sformatf("block_number got %h want %h",
                                               m_block_number, want.block_number));
                    if (m_offset_in_block !== want.offset_in_block)
                        note_failure($sformatf("offset_in_block got %0d want %0d",
                                               m_offset_in_block, want.offset_in_block));
                    if (m_total_blocks !== want.total_blocks)
                        note_failure($sformatf("total_blocks got %h want %h",
                                               m_total_blocks, want.total_blocks));
                    if (m_total_saturated !== want.total_saturated)
                        note_failure($sformatf("total_saturated got %0b want %0b",
                                               m_total_saturated, want.total_saturated));
                    located_seen += want.located;
                    clamped_seen += want.total_saturated;
                end
                results_checked++;
            end
            if (!held_once && results_checked >= 25) begin
                held_once = 1'b1;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 18);
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", idle_cycles);
                $display("extent_offset_locator_core_tb NOT OK");
                $finish;
            end
        end
    end

endmodule
